[hdl/iss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants of the IMU sample segmenter.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int CHANNELS  = 6;
  localparam int SEG_BITS  = 5;   // segment_index field
  localparam int CNT_BITS  = 6;   // segment counter / segment_count register
  localparam int CFG_BITS  = 32;  // widest configuration register
  localparam int IDX_BITS  = 2;   // configuration register index
  localparam int WGT_BITS  = 17;  // interpolation weight, 0..65536
  localparam int WGT_FRAC  = 16;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_START_TIME = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_SEG_LENGTH = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_END_TIME   = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_SEG_COUNT  = 2'd3;

  // back end sequencer
  typedef enum logic [3:0] {
    B_IDLE, B_CLASS, B_BND, B_CMP, B_INTERP, B_EMIT1, B_EMIT2, B_FIN, B_LAST
  } back_state_t;

  // interpolation unit
  typedef enum logic [1:0] {
    I_IDLE, I_SET, I_DIV, I_MUL
  } interp_state_t;

  // which record the sequencer emits
  typedef enum logic [1:0] {
    SRC_HELD, SRC_BND, SRC_NEW
  } emit_src_t;

  // sequencer control for one cycle
  typedef struct packed {
    logic      pop;
    logic      emit;
    emit_src_t src;
    logic      interp_start;
  } back_ctl_t;

endpackage

[hdl/iss_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_front
// Input side: accepts sample words and queues them, two deep, for the back end.
// ----------------------------------------------------------------------------
module iss_front #(
  parameter int TIME_BITS   = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int IN_DW       = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_DW-1:0]        s_tdata,
  input  logic                    s_tuser,
  output logic                    q_valid,
  input  logic                    q_pop,
  output logic                    q_fob,
  output logic [TIME_BITS-1:0]    q_time,
  output logic signed [SAMPLE_BITS-1:0] q_ch [iss_pkg::CHANNELS]
);
  import iss_pkg::*;

  localparam int ITEM_W = 1 + TIME_BITS + CHANNELS * SAMPLE_BITS;

  logic [ITEM_W-1:0] slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;
  logic [ITEM_W-1:0] head;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign head     = slot[rd_ptr];

  // tag each word with its batch flag and store it
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {s_tdata[TIME_BITS+CHANNELS*SAMPLE_BITS-1:0], s_tuser};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // unpack the head entry
  assign q_fob  = head[0];
  assign q_time = head[TIME_BITS:1];
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      q_ch[i] = head[1 + TIME_BITS + i*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

endmodule

[hdl/iss_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_interp
// Boundary interpolation: bit-serial weight division, then one channel blend
// per cycle through a shared multiplier.
// ----------------------------------------------------------------------------
module iss_interp #(
  parameter int TIME_BITS   = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [TIME_BITS-1:0]          held_time,
  input  logic [TIME_BITS-1:0]          new_time,
  input  logic [TIME_BITS-1:0]          bnd_time,
  input  logic signed [SAMPLE_BITS-1:0] held_ch [iss_pkg::CHANNELS],
  input  logic signed [SAMPLE_BITS-1:0] new_ch  [iss_pkg::CHANNELS],
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] res     [iss_pkg::CHANNELS]
);
  import iss_pkg::*;

  localparam int ACC_W = SAMPLE_BITS + 19;

  interp_state_t state, state_next;

  logic [TIME_BITS-1:0] gap;
  logic [TIME_BITS:0]   rem;
  logic [WGT_BITS-1:0]  wgt;
  logic [4:0]           step;
  logic [2:0]           chan;

  logic [TIME_BITS-1:0] gap_c;
  logic [TIME_BITS-1:0] num_c;
  logic [TIME_BITS-1:0] num_cl;
  logic                 ge;
  logic [TIME_BITS:0]   rem_sub;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [ACC_W-1:0]     prod;
  logic signed [ACC_W-1:0]     acc;

  // gap and clamped numerator
  always_comb begin
    gap_c  = (new_time > held_time) ? (new_time - held_time) : TIME_BITS'(1);
    num_c  = (bnd_time > held_time) ? (bnd_time - held_time) : '0;
    num_cl = (num_c > gap_c) ? gap_c : num_c;
  end

  // restoring division step
  assign ge      = (rem >= {1'b0, gap});
  assign rem_sub = ge ? (rem - {1'b0, gap}) : rem;

  // blend: held*65536 + (new - held)*w + half, floor by 65536
  assign diff = $signed({new_ch[chan][SAMPLE_BITS-1], new_ch[chan]})
              - $signed({held_ch[chan][SAMPLE_BITS-1], held_ch[chan]});
  assign prod = ACC_W'(diff) * ACC_W'($signed({1'b0, wgt}));
  assign acc  = (ACC_W'(held_ch[chan]) <<< WGT_FRAC) + prod
              + ACC_W'(1 << (WGT_FRAC - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      I_IDLE: if (start) state_next = I_SET;
      I_SET:  state_next = I_DIV;
      I_DIV:  if (step == 5'(WGT_BITS - 1)) state_next = I_MUL;
      I_MUL:  if (chan == 3'(CHANNELS - 1)) state_next = I_IDLE;
      default: state_next = I_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == I_MUL) && (chan == 3'(CHANNELS - 1));
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      I_SET: begin
        gap  <= gap_c;
        rem  <= {1'b0, num_cl};
        wgt  <= '0;
        step <= '0;
      end
      I_DIV: begin
        wgt  <= {wgt[WGT_BITS-2:0], ge};
        rem  <= {rem_sub[TIME_BITS-1:0], 1'b0};
        step <= step + 5'd1;
        chan <= '0;
      end
      I_MUL: begin
        res[chan] <= acc[WGT_FRAC +: SAMPLE_BITS];
        chan      <= chan + 3'd1;
      end
      default: ;
    endcase
  end

endmodule

[hdl/iss_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_back
// Back end: walks segment boundaries for each queued sample, emits result
// words through a one-deep staging register and an output register.
// ----------------------------------------------------------------------------
module iss_back #(
  parameter int TIME_BITS    = 32,
  parameter int SAMPLE_BITS  = 16,
  parameter int OUT_DW       = 136
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [iss_pkg::CFG_BITS-1:0]  start_time,
  input  logic [iss_pkg::CFG_BITS-1:0]  segment_length,
  input  logic [iss_pkg::CFG_BITS-1:0]  end_time,
  input  logic [iss_pkg::CNT_BITS-1:0]  seg_used,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic                          q_fob,
  input  logic [TIME_BITS-1:0]          q_time,
  input  logic signed [SAMPLE_BITS-1:0] q_ch [iss_pkg::CHANNELS],
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_DW-1:0]             m_tdata,
  output logic                          m_tlast
);
  import iss_pkg::*;

  localparam int REC_W = SEG_BITS + TIME_BITS + CHANNELS * SAMPLE_BITS;
  localparam int BW    = ((TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS) + 7;
  localparam int PW    = CFG_BITS + CNT_BITS;

  back_state_t state, state_next;
  back_ctl_t   ctl;

  // current item
  logic                          it_fob;
  logic [TIME_BITS-1:0]          it_time;
  logic signed [SAMPLE_BITS-1:0] it_ch [CHANNELS];
  // segmenter state
  logic [TIME_BITS-1:0]          held_time;
  logic signed [SAMPLE_BITS-1:0] held_ch [CHANNELS];
  logic [CNT_BITS-1:0]           cur_seg;
  logic                          have_held;
  logic                          first_emitted;
  // boundary sample
  logic [BW-1:0]                 bnd;
  logic signed [SAMPLE_BITS-1:0] bs_ch [CHANNELS];
  // staging and output registers
  logic                          stg_valid;
  logic [REC_W-1:0]              stg_rec;
  logic                          out_valid;
  logic [REC_W-1:0]              out_rec;
  logic                          out_last;

  logic                          out_free;
  logic                          go;
  logic [CNT_BITS-1:0]           seg_next;
  logic [PW-1:0]                 bnd_prod;
  logic [BW-1:0]                 bnd_c;
  logic [BW-1:0]                 t_wide;
  logic                          interp_done;
  logic signed [SAMPLE_BITS-1:0] interp_res [CHANNELS];
  logic [REC_W-1:0]              rec;
  logic                          skip_item;

  assign out_free  = !out_valid || m_tready;
  assign go        = !stg_valid || out_free;
  assign seg_next  = cur_seg + CNT_BITS'(1);
  assign t_wide    = BW'(it_time);
  assign skip_item = it_fob || !have_held || (cur_seg >= seg_used);

  // boundary tick of seg_next
  assign bnd_prod = PW'(segment_length) * PW'(seg_next);
  assign bnd_c    = (seg_next < seg_used) ? (BW'(start_time) + BW'(bnd_prod))
                                          : BW'(end_time);

  iss_interp #(
    .TIME_BITS  (TIME_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_interp (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.interp_start),
    .held_time(held_time),
    .new_time (it_time),
    .bnd_time (bnd[TIME_BITS-1:0]),
    .held_ch  (held_ch),
    .new_ch   (it_ch),
    .done     (interp_done),
    .res      (interp_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (q_valid) state_next = B_CLASS;
      B_CLASS: begin
        if (skip_item)           state_next = B_IDLE;
        else if (first_emitted)  state_next = B_BND;
        else if (go)             state_next = B_BND;
      end
      B_BND:    state_next = B_CMP;
      B_CMP: begin
        if (bnd > t_wide)        state_next = B_FIN;
        else if (bnd == t_wide)  state_next = B_EMIT1;
        else                     state_next = B_INTERP;
      end
      B_INTERP: if (interp_done) state_next = B_EMIT1;
      B_EMIT1:  if (go) state_next = (seg_next < seg_used) ? B_EMIT2 : B_LAST;
      B_EMIT2:  if (go) state_next = B_BND;
      B_FIN:    if (go) state_next = B_LAST;
      B_LAST:   if (!stg_valid || out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '{pop: 1'b0, emit: 1'b0, src: SRC_HELD, interp_start: 1'b0};
    unique case (state)
      B_IDLE:   ctl.pop = q_valid;
      B_CLASS:  ctl.emit = !skip_item && !first_emitted;
      B_CMP:    ctl.interp_start = (bnd < t_wide);
      B_EMIT1, B_EMIT2: begin
        ctl.emit = 1'b1;
        ctl.src  = SRC_BND;
      end
      B_FIN: begin
        ctl.emit = 1'b1;
        ctl.src  = SRC_NEW;
      end
      default: ;
    endcase
  end

  assign q_pop = ctl.pop;

  // record to emit
  always_comb begin
    rec = '0;
    rec[SEG_BITS-1:0] = cur_seg[SEG_BITS-1:0];
    case (ctl.src)
      SRC_HELD: begin
        rec[SEG_BITS +: TIME_BITS] = held_time;
        for (int i = 0; i < CHANNELS; i++)
          rec[SEG_BITS + TIME_BITS + i*SAMPLE_BITS +: SAMPLE_BITS] = held_ch[i];
      end
      SRC_BND: begin
        rec[SEG_BITS +: TIME_BITS] = bnd[TIME_BITS-1:0];
        for (int i = 0; i < CHANNELS; i++)
          rec[SEG_BITS + TIME_BITS + i*SAMPLE_BITS +: SAMPLE_BITS] = bs_ch[i];
      end
      default: begin
        rec[SEG_BITS +: TIME_BITS] = it_time;
        for (int i = 0; i < CHANNELS; i++)
          rec[SEG_BITS + TIME_BITS + i*SAMPLE_BITS +: SAMPLE_BITS] = it_ch[i];
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      cur_seg       <= '0;
      have_held     <= 1'b0;
      first_emitted <= 1'b0;
      stg_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // output register loads from staging, or drains when taken
      if ((ctl.emit && go && stg_valid) ||
          (state == B_LAST && stg_valid && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      // emit: new word is staged
      if (ctl.emit && go) begin
        stg_valid <= 1'b1;
      end
      if (state == B_LAST && stg_valid && out_free) begin
        stg_valid <= 1'b0;
      end
      if (state == B_CLASS) begin
        if (it_fob || !have_held) begin
          cur_seg       <= '0;
          have_held     <= 1'b1;
          first_emitted <= 1'b0;
        end else if (ctl.emit && go) begin
          first_emitted <= 1'b1;
        end
      end
      if (state == B_EMIT1 && go) cur_seg <= seg_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      it_fob  <= q_fob;
      it_time <= q_time;
      it_ch   <= q_ch;
    end
    if (state == B_CLASS && (it_fob || !have_held)) begin
      held_time <= it_time;
      held_ch   <= it_ch;
    end
    if (state == B_BND) bnd <= bnd_c;
    if (state == B_CMP && bnd == t_wide) bs_ch <= it_ch;
    if (state == B_INTERP && interp_done) bs_ch <= interp_res;
    if (state == B_EMIT1 && go) begin
      held_time <= bnd[TIME_BITS-1:0];
      held_ch   <= bs_ch;
    end
    if (state == B_FIN && go) begin
      held_time <= it_time;
      held_ch   <= it_ch;
    end
    if (ctl.emit && go) begin
      stg_rec <= rec;
      if (stg_valid) begin
        out_rec  <= stg_rec;
        out_last <= 1'b0;
      end
    end
    if (state == B_LAST && stg_valid && out_free) begin
      out_rec  <= stg_rec;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DW'(out_rec);
  assign m_tlast  = out_last;

endmodule

[hdl/imu_sample_segmenter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_sample_segmenter
// Sorts time-stamped six-axis IMU samples into time segments, emitting
// linearly interpolated samples at each crossed segment boundary.
// ----------------------------------------------------------------------------
// Boundary work: each interpolated boundary runs a 17-step weight division, then one
//   channel blend per cycle on a shared multiplier; an exact hit skips interpolation.
// Throughput: the back end finishes one sample, with its boundary work and any output
//   stalls, before it takes the next; a two-deep input queue absorbs bursts.
// Reset: synchronous, clears queue, batch state and configuration to defaults.
module imu_sample_segmenter #(
  parameter int MAX_SEGMENTS = 32,
  parameter int TIME_BITS    = 32,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // sample_time, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [((TIME_BITS+6*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // first_of_batch
  input  logic                                 s_tuser,
  // master stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // segment_index, out_time, out_accel_x..z, out_gyro_x..z
  output logic [((5+TIME_BITS+6*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  // last_of_run
  output logic                                 m_tlast,
  // configuration
  input  logic                                 cfg_we,
  input  logic [iss_pkg::IDX_BITS-1:0]         cfg_index,
  input  logic [iss_pkg::CFG_BITS-1:0]         cfg_data
);
  import iss_pkg::*;

  localparam int IN_DW  = ((TIME_BITS + CHANNELS*SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DW = ((SEG_BITS + TIME_BITS + CHANNELS*SAMPLE_BITS + 7) / 8) * 8;

  logic [CFG_BITS-1:0] start_time;
  logic [CFG_BITS-1:0] segment_length;
  logic [CFG_BITS-1:0] end_time;
  logic [CNT_BITS-1:0] segment_count;
  logic [CNT_BITS-1:0] seg_used;

  logic                          q_valid;
  logic                          q_pop;
  logic                          q_fob;
  logic [TIME_BITS-1:0]          q_time;
  logic signed [SAMPLE_BITS-1:0] q_ch [CHANNELS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time     <= '0;
      segment_length <= CFG_BITS'(1000);
      end_time       <= CFG_BITS'(32000);
      segment_count  <= CNT_BITS'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_TIME: start_time     <= cfg_data;
        REG_SEG_LENGTH: segment_length <= cfg_data;
        REG_END_TIME:   end_time       <= cfg_data;
        REG_SEG_COUNT:  segment_count  <= cfg_data[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // segments in use, saturated
  assign seg_used = (segment_count > CNT_BITS'(MAX_SEGMENTS)) ? CNT_BITS'(MAX_SEGMENTS)
                                                              : segment_count;

  iss_front #(
    .TIME_BITS  (TIME_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .IN_DW      (IN_DW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_fob   (q_fob),
    .q_time  (q_time),
    .q_ch    (q_ch)
  );

  iss_back #(
    .TIME_BITS   (TIME_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_DW      (OUT_DW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .start_time    (start_time),
    .segment_length(segment_length),
    .end_time      (end_time),
    .seg_used      (seg_used),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_fob         (q_fob),
    .q_time        (q_time),
    .q_ch          (q_ch),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

endmodule
